/* rtl/core/execution_slot_bitmap_allocator_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the execution slot bitmap allocator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EXECUTION_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`define EXECUTION_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ESBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The expression must hold at every clock edge outside reset.
`define ESBA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`else

`define ESBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ESBA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/core/esba_pkg.sv */
// ----------------------------------------------------------------------------
// esba_pkg
// Shared types and constants of the execution slot bitmap allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esba_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam int MAP_W         = 64;
  localparam int CNT_W         = 7;
  localparam int IDX_W         = 6;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  // Word index of the slot_count register.
  localparam logic REG_SLOT_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_RESERVE_COUNT = 2'd0,
    OP_RESERVE_INDEX = 2'd1,
    OP_FREE_INDEX    = 2'd2,
    OP_RELEASE_MASK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SHORT = 2'd2,
    ST_LARGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } seq_state_t;

  // Sequencer strobes towards the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } ctrl_t;

  // One slot presented to the step unit.
  typedef struct packed {
    op_t  op;
    logic occ;
    logic rel;
    logic hit;
    logic live;
    logic want;
  } step_in_t;

  typedef struct packed {
    logic occ_nxt;
    logic aff;
    logic inc;
    logic dec;
    logic take;
  } step_out_t;

endpackage

`default_nettype wire

/* rtl/core/esba_step_unit.sv */
// ----------------------------------------------------------------------------
// esba_step_unit
// Per-slot update shared by every operation, applied to one slot a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esba_step_unit (
  input  esba_pkg::step_in_t  step_in,
  output esba_pkg::step_out_t step_out
);

  always_comb begin
    step_out = '0;
    step_out.occ_nxt = step_in.occ;
    unique case (step_in.op)
      esba_pkg::OP_RESERVE_COUNT: begin
        // First fit: take a free live slot while the request is not yet met.
        step_out.take    = step_in.live & step_in.want & ~step_in.occ;
        step_out.occ_nxt = step_in.occ | step_out.take;
        step_out.aff     = step_out.take;
        step_out.dec     = step_out.take;
      end
      esba_pkg::OP_RESERVE_INDEX: begin
        step_out.aff     = step_in.hit;
        step_out.dec     = step_in.hit & ~step_in.occ;
        step_out.occ_nxt = step_in.occ | step_in.hit;
      end
      esba_pkg::OP_FREE_INDEX: begin
        step_out.aff     = step_in.hit;
        step_out.inc     = step_in.hit & step_in.occ;
        step_out.occ_nxt = step_in.occ & ~step_in.hit;
      end
      esba_pkg::OP_RELEASE_MASK: begin
        step_out.aff     = step_in.rel;
        step_out.inc     = step_in.rel & step_in.occ;
        step_out.occ_nxt = step_in.occ & ~step_in.rel;
      end
      default: begin
        step_out.occ_nxt = step_in.occ;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/esba_seq.sv */
// ----------------------------------------------------------------------------
// esba_seq
// Sequencer: takes a transaction, walks the slots unless rejected, then hands the result on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esba_seq #(
  parameter int MAX_SLOTS = esba_pkg::MAX_SLOTS_DEF,
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                reject,
  input  logic                out_valid,
  input  logic                out_ready,
  output esba_pkg::ctrl_t     ctrl,
  output logic [SW-1:0]       slot
);

  localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);

  esba_pkg::seq_state_t state_r, state_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esba_pkg::S_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    ctrl      = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      esba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          slot_nxt  = '0;
          // A rejected transaction changes nothing, so no walk is needed.
          state_nxt = reject ? esba_pkg::S_FINISH : esba_pkg::S_SCAN;
        end
      end
      esba_pkg::S_SCAN: begin
        ctrl.step = 1'b1;
        if (slot_r == LAST_SLOT) begin
          slot_nxt  = '0;
          state_nxt = esba_pkg::S_FINISH;
        end else begin
          slot_nxt = slot_r + SW'(1);
        end
      end
      esba_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          ctrl.publish = 1'b1;
          state_nxt    = esba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = esba_pkg::S_IDLE;
      end
    endcase
  end

  assign slot = slot_r;

endmodule

`default_nettype wire

/* rtl/core/execution_slot_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// execution_slot_bitmap_allocator
// First-fit slot allocator over an occupancy bitmap with a free-slot count.
//
// A transaction that is rejected (out of range, too few free slots or a
// release mask reaching past the slots in use) changes nothing and skips the
// walk, going from acceptance straight to the finish state, where its result
// register is written once the output register is free. Every other
// transaction walks the whole bitmap through a single-slot update unit, one
// slot per cycle, before it reaches the finish state. The input is not ready
// from acceptance until the result register is written. A finished result is
// held in an output register, and the next transaction may be accepted while
// it waits, but that transaction cannot finish until the waiting result has
// been taken. Writing slot_count frees every slot at once; no clearing pass
// follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "execution_slot_bitmap_allocator_defines.svh"

module execution_slot_bitmap_allocator #(
  parameter int MAX_SLOTS = esba_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [esba_pkg::APB_AW-1:0]       paddr,
  input  logic [esba_pkg::APB_DW-1:0]       pwdata,
  output logic [esba_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [esba_pkg::CNT_W-1:0]        in_count,
  input  logic [esba_pkg::IDX_W-1:0]        in_slot_index,
  input  logic [esba_pkg::MAP_W-1:0]        in_release_mask,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic [esba_pkg::MAP_W-1:0]        out_affected_mask,
  output logic [esba_pkg::MAP_W-1:0]        out_occupied_map,
  output logic [esba_pkg::CNT_W-1:0]        out_free_slots
);

  localparam int CW = esba_pkg::CNT_W;
  localparam int MW = esba_pkg::MAP_W;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [CW-1:0] SLOT_LIMIT = CW'(MAX_SLOTS);

  // Configuration and allocator state.
  logic [CW-1:0]        slot_count_r;
  logic [MAX_SLOTS-1:0] occ_r;
  logic [CW-1:0]        free_r;

  // Transaction held during the walk.
  esba_pkg::op_t        op_r;
  esba_pkg::status_t    status_r;
  logic [CW-1:0]        count_r;
  logic [esba_pkg::IDX_W-1:0] idx_r;
  logic [MAX_SLOTS-1:0] rel_r;
  logic [MAX_SLOTS-1:0] aff_r;
  logic [CW-1:0]        got_r;

  // Output register.
  logic                 out_valid_r;
  esba_pkg::status_t    out_status_r;
  logic [MW-1:0]        out_aff_r;
  logic [MW-1:0]        out_occ_r;
  logic [CW-1:0]        out_free_r;

  logic [CW-1:0]        live_n;
  logic [MW-1:0]        live_mask;
  logic                 cfg_we;
  esba_pkg::op_t        in_op_c;
  esba_pkg::status_t    status_nxt;
  esba_pkg::ctrl_t      ctrl;
  logic [SW-1:0]        slot;
  esba_pkg::step_in_t   step_in;
  esba_pkg::step_out_t  step_out;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == esba_pkg::REG_SLOT_COUNT);
  assign prdata = (paddr[2] == esba_pkg::REG_SLOT_COUNT) ?
                  esba_pkg::APB_DW'(slot_count_r) : '0;

  assign live_n = (slot_count_r > SLOT_LIMIT) ? SLOT_LIMIT : slot_count_r;

  always_comb begin
    for (int j = 0; j < MW; j++) begin
      live_mask[j] = (CW'(j) < live_n);
    end
  end

  // ------------------------------------------------------------ admission
  assign in_op_c = esba_pkg::op_t'(in_op);

  always_comb begin
    status_nxt = esba_pkg::ST_OK;
    case (in_op_c) inside
      esba_pkg::OP_RESERVE_COUNT: begin
        if (free_r < in_count) status_nxt = esba_pkg::ST_SHORT;
      end
      esba_pkg::OP_RESERVE_INDEX, esba_pkg::OP_FREE_INDEX: begin
        if (CW'(in_slot_index) >= live_n) status_nxt = esba_pkg::ST_RANGE;
      end
      default: begin
        if (|(in_release_mask & ~live_mask)) status_nxt = esba_pkg::ST_LARGE;
      end
    endcase
  end

  esba_seq #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .reject    (status_nxt != esba_pkg::ST_OK),
    .out_valid (out_valid_r),
    .out_ready (out_ready),
    .ctrl      (ctrl),
    .slot      (slot)
  );

  // -------------------------------------------------------------- walk
  // The bitmap rotates right by one slot a cycle, so the slot being worked
  // on always sits at bit 0 and the word is back in order after a full turn.
  always_comb begin
    step_in.op   = op_r;
    step_in.occ  = occ_r[0];
    step_in.rel  = rel_r[0];
    step_in.hit  = (CW'(slot) == CW'(idx_r));
    step_in.live = (CW'(slot) < live_n);
    step_in.want = (got_r < count_r);
  end

  esba_step_unit u_step (
    .step_in  (step_in),
    .step_out (step_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= '0;
      occ_r        <= '0;
      free_r       <= '0;
    end else if (cfg_we) begin
      slot_count_r <= pwdata[CW-1:0];
      occ_r        <= '0;
      free_r       <= (pwdata[CW-1:0] > SLOT_LIMIT) ? SLOT_LIMIT : pwdata[CW-1:0];
    end else if (ctrl.step) begin
      occ_r  <= (occ_r >> 1) | (MAX_SLOTS'(step_out.occ_nxt) << (MAX_SLOTS - 1));
      free_r <= free_r + CW'(step_out.inc) - CW'(step_out.dec);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_r     <= in_op_c;
      status_r <= status_nxt;
      count_r  <= in_count;
      idx_r    <= in_slot_index;
      rel_r    <= in_release_mask[MAX_SLOTS-1:0];
      aff_r    <= '0;
      got_r    <= '0;
    end else if (ctrl.step) begin
      rel_r <= rel_r >> 1;
      aff_r <= (aff_r >> 1) | (MAX_SLOTS'(step_out.aff) << (MAX_SLOTS - 1));
      got_r <= got_r + CW'(step_out.take);
    end
  end

  // ------------------------------------------------------------ result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.publish) begin
      out_status_r <= status_r;
      out_aff_r    <= MW'(aff_r);
      out_occ_r    <= MW'(occ_r);
      out_free_r   <= free_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_affected_mask = out_aff_r;
  assign out_occupied_map  = out_occ_r;
  assign out_free_slots    = out_free_r;

  // ---------------------------------------------------------- assertions
  `ESBA_ASSERT_ALWAYS(a_free_within_live, clk, rst_n, free_r <= live_n, "free count exceeds live slots")
  `ESBA_ASSERT_IMP(a_no_dead_occupied, clk, rst_n, !ctrl.step, (MW'(occ_r) & ~live_mask) == '0, "slot beyond slot_count is occupied")
  `ESBA_ASSERT_IMP(a_reserve_exact, clk, rst_n, ctrl.publish && op_r == esba_pkg::OP_RESERVE_COUNT && status_r == esba_pkg::ST_OK, $countones(aff_r) == int'(count_r), "reserve did not grant the requested count")
  `ESBA_ASSERT_IMP(a_reject_no_slots, clk, rst_n, ctrl.publish && status_r != esba_pkg::ST_OK, aff_r == '0, "rejected transaction reports affected slots")

endmodule

`default_nettype wire

/* test/tb_execution_slot_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// Testbench for the execution slot bitmap allocator
// Runs a table of directed requests and then several phases of random
// requests under different slot counts. Each result is checked against its
// table row or a bit-accurate software model of the occupancy bitmap and
// free count. Both handshakes see random gaps outside the steady phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_execution_slot_bitmap_allocator;
  import esba_pkg::*;

  localparam logic [63:0] ALL_SLOTS = {64{1'b1}};
  localparam int N_DIRECTED = 25;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 112;

  typedef struct packed {
    status_t     status;
    logic [63:0] affected;
    logic [63:0] occupied;
    logic [6:0]  free;
  } alloc_result_t;

  typedef struct packed {
    logic        cfg_write;
    logic [6:0]  cfg_value;
    op_t         op;
    logic [6:0]  count;
    logic [5:0]  idx;
    logic [63:0] mask;
    logic        typed;
    status_t     st;
    logic [63:0] aff;
    logic [63:0] occ;
    logic [6:0]  free;
  } stim_row_t;

  // A row that writes slot_count does so, once the block is idle, before its request.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{1'b0, 7'd0, OP_RESERVE_COUNT, 7'd0, 6'd0, 64'd0, 1'b1, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_COUNT, 7'd64, 6'd0, 64'd0, 1'b1, ST_SHORT, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_INDEX, 7'd0, 6'd0, 64'd0, 1'b1, ST_RANGE, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_FREE_INDEX, 7'd0, 6'd63, 64'd0, 1'b1, ST_RANGE, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RELEASE_MASK, 7'd0, 6'd0, 64'd0, 1'b1, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RELEASE_MASK, 7'd0, 6'd0, ALL_SLOTS, 1'b1, ST_LARGE, 64'd0, 64'd0, 7'd0},
    '{1'b1, 7'd64, OP_RESERVE_COUNT, 7'd64, 6'd0, 64'd0,
      1'b1, ST_OK, ALL_SLOTS, ALL_SLOTS, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_COUNT, 7'd1, 6'd0, 64'd0, 1'b1, ST_SHORT, 64'd0, ALL_SLOTS, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_INDEX, 7'd0, 6'd63, 64'd0,
      1'b1, ST_OK, 64'h8000_0000_0000_0000, ALL_SLOTS, 7'd0},
    '{1'b0, 7'd0, OP_RELEASE_MASK, 7'd0, 6'd0, ALL_SLOTS, 1'b1, ST_OK, ALL_SLOTS, 64'd0, 7'd64},
    '{1'b0, 7'd0, OP_RELEASE_MASK, 7'd0, 6'd0, ALL_SLOTS, 1'b1, ST_OK, ALL_SLOTS, 64'd0, 7'd64},
    '{1'b0, 7'd0, OP_FREE_INDEX, 7'd0, 6'd0, 64'd0, 1'b1, ST_OK, 64'd1, 64'd0, 7'd64},
    '{1'b0, 7'd0, OP_RESERVE_INDEX, 7'd0, 6'd0, 64'd0, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_INDEX, 7'd0, 6'd63, 64'd0, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_COUNT, 7'd3, 6'd0, 64'd0, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_COUNT, 7'd0, 6'd0, 64'd0, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_COUNT, 7'd127, 6'd0, 64'd0, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_FREE_INDEX, 7'd0, 6'd1, 64'd0, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RELEASE_MASK, 7'd0, 6'd0, 64'h5, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b1, 7'd127, OP_RESERVE_COUNT, 7'd64, 6'd0, 64'd0,
      1'b1, ST_OK, ALL_SLOTS, ALL_SLOTS, 7'd0},
    '{1'b1, 7'd5, OP_RESERVE_INDEX, 7'd0, 6'd5, 64'd0, 1'b1, ST_RANGE, 64'd0, 64'd0, 7'd5},
    '{1'b0, 7'd0, OP_RELEASE_MASK, 7'd0, 6'd0, 64'h20, 1'b1, ST_LARGE, 64'd0, 64'd0, 7'd5},
    '{1'b0, 7'd0, OP_RELEASE_MASK, 7'd0, 6'd0, 64'h1f, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_COUNT, 7'd6, 6'd0, 64'd0, 1'b0, ST_OK, 64'd0, 64'd0, 7'd0},
    '{1'b0, 7'd0, OP_RESERVE_COUNT, 7'd5, 6'd0, 64'd0, 1'b1, ST_OK, 64'h1f, 64'h1f, 7'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = 2'd0;
  logic [CNT_W-1:0] in_count = '0;
  logic [IDX_W-1:0] in_slot_index = '0;
  logic [MAP_W-1:0] in_release_mask = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [MAP_W-1:0] out_affected_mask;
  logic [MAP_W-1:0] out_occupied_map;
  logic [CNT_W-1:0] out_free_slots;

  // Software copy of the allocator state.
  logic [6:0]  slot_count_cfg = 7'd0;
  logic [63:0] occ_track = 64'd0;
  logic [6:0]  free_track = 7'd0;

  alloc_result_t pending_results [$];
  int faults = 0;
  int results_checked = 0;
  int rejected_seen = 0;
  int requests_sent = 0;
  int settings_used = 0;
  bit steady_phase = 1'b0;
  int ready_hold = 0;

  execution_slot_bitmap_allocator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_count         (in_count),
    .in_slot_index    (in_slot_index),
    .in_release_mask  (in_release_mask),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_affected_mask(out_affected_mask),
    .out_occupied_map (out_occupied_map),
    .out_free_slots   (out_free_slots)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_slot_count();
    return (slot_count_cfg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(slot_count_cfg);
  endfunction

  function automatic logic [63:0] live_slot_bits();
    int n;
    n = live_slot_count();
    return (n >= 64) ? ALL_SLOTS : ((64'd1 << n) - 64'd1);
  endfunction

  // Applies one request to the tracked state and returns the result it gives.
  function automatic alloc_result_t predict_allocation(input op_t op, input logic [6:0] cnt,
                                                      input logic [5:0] idx,
                                                      input logic [63:0] rel);
    alloc_result_t res;
    int n;
    int got;
    logic [63:0] b;
    n = live_slot_count();
    got = 0;
    res.status = ST_OK;
    res.affected = 64'd0;
    case (op) inside
      OP_RESERVE_COUNT: begin
        if (free_track < cnt) begin
          res.status = ST_SHORT;
        end else begin
          for (int i = 0; i < n && got < cnt; i++) begin
            b = 64'd1 << i;
            if ((occ_track & b) == 64'd0) begin
              occ_track = occ_track | b;
              res.affected = res.affected | b;
              got++;
            end
          end
          free_track = free_track - 7'(got);
        end
      end
      OP_RESERVE_INDEX, OP_FREE_INDEX: begin
        if (int'(idx) >= n) begin
          res.status = ST_RANGE;
        end else begin
          b = 64'd1 << idx;
          res.affected = b;
          if (op == OP_RESERVE_INDEX && (occ_track & b) == 64'd0) begin
            occ_track = occ_track | b;
            free_track = free_track - 7'd1;
          end else if (op == OP_FREE_INDEX && (occ_track & b) != 64'd0) begin
            occ_track = occ_track & ~b;
            free_track = free_track + 7'd1;
          end
        end
      end
      default: begin
        if ((rel & ~live_slot_bits()) != 64'd0) begin
          res.status = ST_LARGE;
        end else begin
          free_track = free_track + 7'($countones(occ_track & rel));
          occ_track = occ_track & ~rel;
          res.affected = rel;
        end
      end
    endcase
    res.occupied = occ_track;
    res.free = free_track;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 24);
    return $urandom_range(60, 200);
  endfunction

  // Called just after a rising edge; returns at the edge that accepts the request.
  task automatic send_request(input op_t op, input logic [6:0] cnt, input logic [5:0] idx,
                              input logic [63:0] rel, input bit typed,
                              input alloc_result_t typed_res);
    int gap;
    alloc_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_count <= cnt;
    in_slot_index <= idx;
    in_release_mask <= rel;
    do @(posedge clk); while (!in_ready);
    res = predict_allocation(op, cnt, idx, rel);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [6:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SLOT_COUNT, 2'b00};
    pwdata <= {{(APB_DW-7){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    slot_count_cfg = value;
    occ_track = 64'd0;
    free_track = 7'(live_slot_count());
    settings_used++;
  endtask

  // Result side: random back-pressure, held off entirely during steady phases.
  always @(posedge clk) begin
    if (steady_phase) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if (out_ready) begin
      ready_hold = pick_gap();
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold = ready_hold - 1;
      end else begin
        ready_hold = $urandom_range(0, 8);
      end
    end else begin
      out_ready <= 1'b1;
      ready_hold = $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (faults < 10)
          $display("[%0t] result with nothing expected: status %0d occupied %h free %0d",
                   $realtime, out_status, out_occupied_map, out_free_slots);
        faults++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status != ST_OK) rejected_seen++;
        if (out_status !== want.status || out_affected_mask !== want.affected ||
            out_occupied_map !== want.occupied || out_free_slots !== want.free) begin
          if (faults < 10) begin
            $display("[%0t] result %0d mismatch: status exp %0d got %0d, affected exp %h got %h",
                     $realtime, results_checked, want.status, out_status, want.affected,
                     out_affected_mask);
            $display("    occupied exp %h got %h, free exp %0d got %0d",
                     want.occupied, out_occupied_map, want.free, out_free_slots);
          end
          faults++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("execution_slot_bitmap_allocator test failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    alloc_result_t typed_res;
    logic [6:0] slots;
    logic [6:0] cnt;
    logic [5:0] idx;
    logic [63:0] rel;
    op_t op;
    int n;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      row = directed_rows[r];
      if (row.cfg_write) begin
        wait_idle();
        write_slot_count(row.cfg_value);
      end
      typed_res.status = row.st;
      typed_res.affected = row.aff;
      typed_res.occupied = row.occ;
      typed_res.free = row.free;
      send_request(row.op, row.count, row.idx, row.mask, row.typed, typed_res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: slots = 7'd64;
        1: slots = 7'd1;
        2: slots = 7'd127;
        3: slots = 7'd0;
        5: slots = 7'd64;
        6: slots = 7'($urandom_range(65, 126));
        default: slots = 7'($urandom_range(2, 63));
      endcase
      wait_idle();
      steady_phase = (ph == 2 || ph == 5);
      write_slot_count(slots);
      n = live_slot_count();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        op = op_t'($urandom_range(0, 3));
        // Mostly well-formed requests, so that the bitmap fills and drains.
        if ($urandom_range(0, 99) < 75)
          cnt = 7'($urandom_range(0, int'(free_track)));
        else
          cnt = 7'($urandom_range(0, 127));
        if (n > 0 && $urandom_range(0, 99) < 85)
          idx = 6'($urandom_range(0, n - 1));
        else
          idx = 6'($urandom_range(0, 63));
        rel = {$urandom, $urandom};
        case ($urandom_range(0, 9)) inside
          0: rel = ALL_SLOTS;
          1: rel = 64'd0;
          [2:3]: ;
          [4:5]: rel = rel & occ_track & live_slot_bits();
          default: rel = rel & live_slot_bits();
        endcase
        send_request(op, cnt, idx, rel, 1'b0, typed_res);
      end
    end

    steady_phase = 1'b0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d requests over %0d slot_count settings; %0d results compared, %0d rejected.",
             requests_sent, settings_used, results_checked, rejected_seen);
    if (faults == 0 && pending_results.size() == 0) begin
      $display("execution_slot_bitmap_allocator test passed");
    end else begin
      $display("%0d faulty results", faults);
      $display("execution_slot_bitmap_allocator test failed");
    end
    $finish;
  end

endmodule
